### sv/positional_linked_list_manager_defines.svh
// Assertion macros shared by the checker of the positional linked list manager.
// Depends on nothing; the asserting module must provide clk and arst_n.
`ifndef POSITIONAL_LINKED_LIST_MANAGER_DEFINES_SVH
`define POSITIONAL_LINKED_LIST_MANAGER_DEFINES_SVH

`define PLM_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("plm_checker: property violated");

`define PLM_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("plm_checker: property violated");

`endif

### sv/plm_pkg.sv
// Package of the positional linked list manager: sizes, codes, state and memory request types.
// Depends on nothing; used by the controller, the top level and the checker.
`default_nettype none

package plm_pkg;

	localparam int CAPACITY = 32;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int LINK_W   = $clog2(CAPACITY + 1);
	localparam int CNT_W    = LINK_W;
	localparam int DATA_W   = 32;

	localparam logic [LINK_W-1:0] NIL = LINK_W'(CAPACITY);

	typedef enum logic [2:0] {
		REQ_PUSH_FRONT,
		REQ_PUSH_BACK,
		REQ_INSERT,
		REQ_POP_FRONT,
		REQ_POP_BACK,
		REQ_ERASE,
		REQ_TRAVERSE,
		REQ_NONE
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_RANGE,
		STAT_FULL,
		STAT_EMPTY
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_TAKE,
		S_GRAB,
		S_WSTART,
		S_WSTEP,
		S_INS_B,
		S_DEL_RD,
		S_DEL_A,
		S_DEL_B,
		S_REPLY,
		S_TSTART,
		S_TEMIT
	} state_t;

	typedef struct packed {
		logic              link_we;
		logic [ADDR_W-1:0] link_waddr;
		logic [LINK_W-1:0] link_wdata;
		logic              val_we;
		logic [ADDR_W-1:0] val_waddr;
		logic [DATA_W-1:0] val_wdata;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

endpackage

`default_nettype wire

### sv/plm_ram.sv
// Generic single write port, single read port RAM with a registered read (read-first).
// Depends on nothing.
`default_nettype none

module plm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### sv/plm_ctrl.sv
// Controller of the positional linked list manager: request decode, link walker and results.
// Depends on plm_pkg; drives the link and value memories through a mem_req_t.
`default_nettype none

module plm_ctrl import plm_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [2:0]               req_type,
	input  wire logic [6:0]               position,
	input  wire logic signed [DATA_W-1:0] value,
	input  wire logic [LINK_W-1:0]        link_rdata,
	input  wire logic [DATA_W-1:0]        val_rdata,
	output logic                          busy,
	output mem_req_t                      mem,
	output logic                          result_valid,
	output logic [1:0]                    status,
	output logic                          element_valid,
	output logic signed [DATA_W-1:0]      element_value,
	output logic [6:0]                    element_count,
	output logic                          last
);

	state_t            state_q, state_d;
	logic [ADDR_W-1:0] clr_q;
	logic [LINK_W-1:0] head_q, free_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  rem_q;
	logic [LINK_W-1:0] addr_q, new_q, prev_q, gone_q;
	logic [DATA_W-1:0] val_q;
	logic              ins_q, front_q;
	status_t           stat_q;

	logic              rv_q, oev_q, olast_q;
	status_t           ost_q;
	logic [DATA_W-1:0] oval_q;
	logic [6:0]        ocnt_q;

	logic [7:0]        pos8, cnt8, d_k;
	logic              full, empty, accept;
	state_t            d_goto;
	status_t           d_stat;
	logic              d_ins;

	logic              emit, e_ev, e_last;
	status_t           e_stat;
	logic [DATA_W-1:0] e_val;

	assign pos8   = {1'b0, position};
	assign cnt8   = 8'(count_q);
	assign full   = (count_q == CNT_W'(CAPACITY));
	assign empty  = (count_q == '0);
	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	always_comb begin
		d_goto = S_REPLY;
		d_stat = STAT_OK;
		d_ins  = 1'b0;
		d_k    = 8'd1;
		case (req_t'(req_type))
			REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
				if (full) begin
					d_stat = STAT_FULL;
				end else begin
					d_goto = S_TAKE;
					d_ins  = 1'b1;
					d_k    = (req_t'(req_type) == REQ_PUSH_FRONT) ? 8'd1 : cnt8 + 8'd1;
				end
			end
			REQ_INSERT: begin
				if (pos8 == 8'd0 || pos8 > cnt8 + 8'd1) begin
					d_stat = STAT_RANGE;
				end else if (full) begin
					d_stat = STAT_FULL;
				end else begin
					d_goto = S_TAKE;
					d_ins  = 1'b1;
					d_k    = pos8;
				end
			end
			REQ_POP_FRONT, REQ_POP_BACK: begin
				if (empty) begin
					d_stat = STAT_EMPTY;
				end else begin
					d_k    = (req_t'(req_type) == REQ_POP_FRONT) ? 8'd1 : cnt8;
					d_goto = (d_k == 8'd1) ? S_DEL_RD : S_WSTART;
				end
			end
			REQ_ERASE: begin
				if (pos8 == 8'd0 || pos8 > cnt8) begin
					d_stat = STAT_RANGE;
				end else begin
					d_k    = pos8;
					d_goto = (d_k == 8'd1) ? S_DEL_RD : S_WSTART;
				end
			end
			REQ_TRAVERSE: begin
				if (!empty) begin
					d_goto = S_TSTART;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == ADDR_W'(CAPACITY - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					state_d = d_goto;
				end
			end
			S_TAKE:   state_d = S_GRAB;
			S_GRAB:   state_d = front_q ? S_REPLY : S_WSTART;
			S_WSTART: state_d = S_WSTEP;
			S_WSTEP: begin
				if (rem_q == '0) begin
					state_d = ins_q ? S_INS_B : S_DEL_RD;
				end
			end
			S_INS_B:  state_d = S_REPLY;
			S_DEL_RD: state_d = S_DEL_A;
			S_DEL_A:  state_d = S_DEL_B;
			S_DEL_B:  state_d = S_REPLY;
			S_REPLY:  state_d = S_IDLE;
			S_TSTART: state_d = S_TEMIT;
			S_TEMIT: begin
				if (rem_q == '0) begin
					state_d = S_IDLE;
				end
			end
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		mem    = '0;
		emit   = 1'b0;
		e_stat = STAT_OK;
		e_ev   = 1'b0;
		e_val  = '0;
		e_last = 1'b1;
		case (state_q)
			S_CLEAR: begin
				mem.link_we    = 1'b1;
				mem.link_waddr = clr_q;
				mem.link_wdata = LINK_W'(clr_q) + LINK_W'(1);
			end
			S_TAKE: begin
				mem.raddr     = free_q[ADDR_W-1:0];
				mem.val_we    = 1'b1;
				mem.val_waddr = free_q[ADDR_W-1:0];
				mem.val_wdata = val_q;
			end
			S_GRAB: begin
				if (front_q) begin
					mem.link_we    = 1'b1;
					mem.link_waddr = free_q[ADDR_W-1:0];
					mem.link_wdata = head_q;
				end
			end
			S_WSTART, S_TSTART: begin
				mem.raddr = head_q[ADDR_W-1:0];
			end
			S_WSTEP: begin
				if (rem_q != '0) begin
					mem.raddr = link_rdata[ADDR_W-1:0];
				end else if (ins_q) begin
					mem.link_we    = 1'b1;
					mem.link_waddr = new_q[ADDR_W-1:0];
					mem.link_wdata = link_rdata;
				end
			end
			S_INS_B: begin
				mem.link_we    = 1'b1;
				mem.link_waddr = prev_q[ADDR_W-1:0];
				mem.link_wdata = new_q;
			end
			S_DEL_RD: begin
				mem.raddr = gone_q[ADDR_W-1:0];
			end
			S_DEL_A: begin
				if (!front_q) begin
					mem.link_we    = 1'b1;
					mem.link_waddr = prev_q[ADDR_W-1:0];
					mem.link_wdata = link_rdata;
				end
			end
			S_DEL_B: begin
				mem.link_we    = 1'b1;
				mem.link_waddr = gone_q[ADDR_W-1:0];
				mem.link_wdata = free_q;
			end
			S_REPLY: begin
				emit   = 1'b1;
				e_stat = stat_q;
			end
			S_TEMIT: begin
				mem.raddr = link_rdata[ADDR_W-1:0];
				emit      = 1'b1;
				e_ev      = 1'b1;
				e_val     = val_rdata;
				e_last    = (rem_q == '0);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			head_q  <= NIL;
			free_q  <= '0;
			count_q <= '0;
			rv_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			rv_q    <= emit;
			case (state_q)
				S_CLEAR: clr_q <= clr_q + ADDR_W'(1);
				S_IDLE: begin
					if (accept && d_goto != S_REPLY && d_goto != S_TSTART) begin
						count_q <= d_ins ? count_q + CNT_W'(1) : count_q - CNT_W'(1);
					end
				end
				S_GRAB: begin
					free_q <= link_rdata;
					if (front_q) begin
						head_q <= free_q;
					end
				end
				S_DEL_A: begin
					if (front_q) begin
						head_q <= link_rdata;
					end
				end
				S_DEL_B: free_q <= gone_q;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					val_q   <= value;
					stat_q  <= d_stat;
					ins_q   <= d_ins;
					front_q <= (d_k == 8'd1);
					gone_q  <= head_q;
					rem_q   <= (d_goto == S_TSTART) ? count_q - CNT_W'(1) : CNT_W'(d_k - 8'd2);
				end
			end
			S_GRAB:   new_q <= free_q;
			S_WSTART: addr_q <= head_q;
			S_WSTEP: begin
				if (rem_q != '0) begin
					addr_q <= link_rdata;
					rem_q  <= rem_q - CNT_W'(1);
				end else begin
					prev_q <= addr_q;
					if (!ins_q) begin
						gone_q <= link_rdata;
					end
				end
			end
			S_TEMIT:  rem_q <= rem_q - CNT_W'(1);
			default: begin
			end
		endcase
		if (emit) begin
			ost_q   <= e_stat;
			oev_q   <= e_ev;
			oval_q  <= e_val;
			ocnt_q  <= 7'(count_q);
			olast_q <= e_last;
		end
	end

	assign result_valid  = rv_q;
	assign status        = ost_q;
	assign element_valid = oev_q;
	assign element_value = oval_q;
	assign element_count = ocnt_q;
	assign last          = olast_q;

endmodule

`default_nettype wire

### sv/positional_linked_list_manager.sv
// Top level: link and value memories (plm_ram) around the controller (plm_ctrl); uses plm_pkg.
// A rejected request goes straight to the reply; a push or insert takes a free cell and, past the
// front, walks the links to position k (a back push has k = count+1), as an erase or pop does.
// Traverse reads the head in S_TSTART, then shows one element per cycle. Busy falls as the final
// result is shown, so one request is in flight at a time.
// After reset the link memory is chained into the free list with busy high.
`default_nettype none

module positional_linked_list_manager import plm_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [2:0]               req_type,
	input  wire logic [6:0]               position,
	input  wire logic signed [DATA_W-1:0] value,
	output logic                          result_valid,
	output logic [1:0]                    status,
	output logic                          element_valid,
	output logic signed [DATA_W-1:0]      element_value,
	output logic [6:0]                    element_count,
	output logic                          last
);

	mem_req_t          mem;
	logic [LINK_W-1:0] link_rdata;
	logic [DATA_W-1:0] val_rdata;

	plm_ram #(
		.WIDTH(LINK_W),
		.DEPTH(CAPACITY)
	) u_link_ram (
		.clk   (clk),
		.we    (mem.link_we),
		.waddr (mem.link_waddr),
		.wdata (mem.link_wdata),
		.raddr (mem.raddr),
		.rdata (link_rdata)
	);

	plm_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CAPACITY)
	) u_val_ram (
		.clk   (clk),
		.we    (mem.val_we),
		.waddr (mem.val_waddr),
		.wdata (mem.val_wdata),
		.raddr (mem.raddr),
		.rdata (val_rdata)
	);

	plm_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.req_type      (req_type),
		.position      (position),
		.value         (value),
		.link_rdata    (link_rdata),
		.val_rdata     (val_rdata),
		.busy          (busy),
		.mem           (mem),
		.result_valid  (result_valid),
		.status        (status),
		.element_valid (element_valid),
		.element_value (element_value),
		.element_count (element_count),
		.last          (last)
	);

endmodule

`default_nettype wire

### sv/plm_checker.sv
// Port-level checker of the positional linked list manager, bound to the top level.
// Depends on plm_pkg and positional_linked_list_manager_defines.svh.
`default_nettype none

`include "positional_linked_list_manager_defines.svh"

module plm_checker import plm_pkg::*; (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     start,
	input wire logic                     busy,
	input wire logic [2:0]               req_type,
	input wire logic [6:0]               position,
	input wire logic signed [DATA_W-1:0] value,
	input wire logic                     result_valid,
	input wire logic [1:0]               status,
	input wire logic                     element_valid,
	input wire logic signed [DATA_W-1:0] element_value,
	input wire logic [6:0]               element_count,
	input wire logic                     last
);

	// A traversal run comes out on consecutive cycles until its final transaction.
	`PLM_ASSERT_NXT(a_run_unbroken, result_valid && !last, result_valid)
	`PLM_ASSERT_NXT(a_busy_after_accept, start && !busy, busy)
	`PLM_ASSERT_IMP(a_idle_with_final, result_valid && last, !busy)
	`PLM_ASSERT_IMP(a_single_result, result_valid && !element_valid, last && element_value == '0)
	`PLM_ASSERT_IMP(a_element_ok, result_valid && element_valid, status == STAT_OK)

endmodule

bind positional_linked_list_manager plm_checker u_plm_checker (.*);

`default_nettype wire

### dv/tb_positional_linked_list_manager.sv
// Self-checking testbench for the positional linked list manager: directed and random requests,
// each checked against a queue-based model of the list. Depends on plm_pkg and the block's RTL.
module tb_positional_linked_list_manager import plm_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 410;
	localparam int DRAIN_CYCLES = 2 * CAPACITY + 20;

	typedef enum int {
		MODE_GROW,
		MODE_SHRINK,
		MODE_MIX
	} mix_mode_t;

	typedef struct {
		status_t     status;
		logic        element_valid;
		logic [31:0] element_value;
		logic [6:0]  element_count;
		logic        last;
	} list_result_t;

	class list_shadow;
		logic [31:0]  items[$];
		list_result_t pending[$];
		int errors, checked, requests, full_hits, empty_hits, range_hits, traversals;

		function void add_result(status_t st, logic ev, logic [31:0] val, logic lst);
			list_result_t r;
			r.status        = st;
			r.element_valid = ev;
			r.element_value = val;
			r.element_count = 7'(items.size());
			r.last          = lst;
			pending.push_back(r);
		endfunction

		function void note_request(req_t kind, logic [6:0] pos, logic [31:0] val);
			status_t st;
			int      n;
			int      i;
			st = STAT_OK;
			n  = items.size();
			requests++;
			case (kind)
				REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
					if (n >= CAPACITY)
						st = STAT_FULL;
					else if (kind == REQ_PUSH_FRONT)
						items.push_front(val);
					else
						items.push_back(val);
				end
				REQ_INSERT: begin
					if (pos < 1 || pos > n + 1)
						st = STAT_RANGE;
					else if (n >= CAPACITY)
						st = STAT_FULL;
					else
						items.insert(pos - 1, val);
				end
				REQ_POP_FRONT, REQ_POP_BACK: begin
					if (n == 0)
						st = STAT_EMPTY;
					else if (kind == REQ_POP_FRONT)
						void'(items.pop_front());
					else
						void'(items.pop_back());
				end
				REQ_ERASE: begin
					if (pos < 1 || pos > n)
						st = STAT_RANGE;
					else
						items.delete(pos - 1);
				end
				REQ_TRAVERSE: begin
					traversals++;
					if (n > 0) begin
						for (i = 0; i < n; i++)
							add_result(STAT_OK, 1'b1, items[i], i == n - 1);
						return;
					end
				end
				default: ;
			endcase
			if (st == STAT_FULL) full_hits++;
			if (st == STAT_EMPTY) empty_hits++;
			if (st == STAT_RANGE) range_hits++;
			add_result(st, 1'b0, 32'd0, 1'b1);
		endfunction

		function void check_result(logic [1:0] st, logic ev, logic [31:0] val, logic [6:0] cnt,
				logic lst);
			list_result_t e;
			if (pending.size() == 0) begin
				$error("unexpected result: status %0d value %0d count %0d", st, $signed(val), cnt);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (st !== e.status) begin
				$error("status mismatch: expected %0d, actual %0d", e.status, st);
				errors++;
			end
			if (ev !== e.element_valid) begin
				$error("element_valid mismatch: expected %0d, actual %0d", e.element_valid, ev);
				errors++;
			end
			if (val !== e.element_value) begin
				$error("element_value mismatch: expected %0d, actual %0d",
					$signed(e.element_value), $signed(val));
				errors++;
			end
			if (cnt !== e.element_count) begin
				$error("element_count mismatch: expected %0d, actual %0d", e.element_count, cnt);
				errors++;
			end
			if (lst !== e.last) begin
				$error("last mismatch: expected %0d, actual %0d", e.last, lst);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  req_type;
	logic [6:0]  position;
	logic [31:0] value;
	logic        result_valid;
	logic [1:0]  status;
	logic        element_valid;
	logic [31:0] element_value;
	logic [6:0]  element_count;
	logic        last;

	list_shadow sb = new();
	int         idle_pct;

	positional_linked_list_manager uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.position      (position),
		.value         (value),
		.result_valid  (result_valid),
		.status        (status),
		.element_valid (element_valid),
		.element_value (element_value),
		.element_count (element_count),
		.last          (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_valid === 1'b1)
			sb.check_result(status, element_valid, element_value, element_count, last);
	end

	// Start stays high from one transaction to the next unless an idle gap is taken.
	task automatic send_req(input req_t kind, input logic [6:0] pos, input logic [31:0] val);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < idle_pct && gap < 20)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start    <= 1'b1;
		req_type <= kind;
		position <= pos;
		value    <= val;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		sb.note_request(kind, pos, val);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_random(input mix_mode_t mode);
		int         r;
		int         n;
		req_t       kind;
		logic [6:0] pos;
		r = $urandom_range(0, 99);
		n = sb.items.size();
		case (mode)
			MODE_GROW: begin
				if (r < 30) kind = REQ_PUSH_FRONT;
				else if (r < 60) kind = REQ_PUSH_BACK;
				else if (r < 88) kind = REQ_INSERT;
				else if (r < 93) kind = REQ_TRAVERSE;
				else if (r < 98) kind = (r[0]) ? REQ_ERASE : REQ_POP_BACK;
				else kind = REQ_NONE;
			end
			MODE_SHRINK: begin
				if (r < 30) kind = REQ_POP_FRONT;
				else if (r < 55) kind = REQ_POP_BACK;
				else if (r < 85) kind = REQ_ERASE;
				else if (r < 92) kind = REQ_TRAVERSE;
				else if (r < 98) kind = REQ_PUSH_BACK;
				else kind = REQ_NONE;
			end
			default: begin
				if (r < 97) kind = req_t'($urandom_range(0, 6));
				else kind = REQ_NONE;
			end
		endcase
		pos = 7'($urandom_range(0, 127));
		if ($urandom_range(0, 99) < 85) begin
			if (kind == REQ_INSERT)
				pos = 7'($urandom_range(1, n + 1));
			else if (kind == REQ_ERASE && n > 0)
				pos = 7'($urandom_range(1, n));
		end
		send_req(kind, pos, pick_value());
	endtask

	initial begin
		mix_mode_t mode;
		int        left_in_mode;
		int        k;
		arst_n   = 1'b0;
		start    = 1'b0;
		req_type = 3'd0;
		position = 7'd0;
		value    = 32'd0;
		idle_pct = 18;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		send_req(REQ_TRAVERSE, 7'd0, 32'd0);
		send_req(REQ_POP_FRONT, 7'd0, 32'd0);
		send_req(REQ_POP_BACK, 7'd0, 32'd0);
		send_req(REQ_ERASE, 7'd1, 32'd0);
		send_req(REQ_INSERT, 7'd0, 32'h1111_1111);
		send_req(REQ_INSERT, 7'd2, 32'h2222_2222);
		send_req(REQ_ERASE, 7'd0, 32'd0);
		send_req(REQ_INSERT, 7'd1, 32'h8000_0000);
		send_req(REQ_PUSH_BACK, 7'd0, 32'h7fff_ffff);
		send_req(REQ_PUSH_FRONT, 7'd127, 32'hffff_ffff);
		send_req(REQ_INSERT, 7'd4, 32'h0000_0000);
		send_req(REQ_INSERT, 7'd127, 32'h3333_3333);
		send_req(REQ_INSERT, 7'd3, 32'h5a5a_5a5a);
		send_req(REQ_ERASE, 7'd127, 32'd0);
		send_req(REQ_TRAVERSE, 7'd0, 32'd0);
		send_req(REQ_ERASE, 7'd3, 32'd0);
		send_req(REQ_ERASE, 7'd4, 32'd0);
		send_req(REQ_POP_BACK, 7'd0, 32'd0);
		send_req(REQ_POP_FRONT, 7'd0, 32'd0);
		send_req(REQ_NONE, 7'd85, 32'ha5a5_a5a5);
		send_req(REQ_PUSH_FRONT, 7'd0, 32'd0);
		send_req(REQ_TRAVERSE, 7'd0, 32'd0);
		send_req(REQ_ERASE, 7'd1, 32'd0);
		send_req(REQ_TRAVERSE, 7'd0, 32'd0);

		// The first episode grows the list towards its capacity.
		mode         = MODE_GROW;
		left_in_mode = 45;
		for (k = 0; k < RANDOM_ITEMS; k++) begin
			if (k == RANDOM_ITEMS / 3)
				idle_pct = 45;
			else if (k == 2 * RANDOM_ITEMS / 3)
				idle_pct = 0;
			if (left_in_mode == 0) begin
				mode         = mix_mode_t'($urandom_range(0, 2));
				left_in_mode = $urandom_range(8, 45);
			end
			send_random(mode);
			left_in_mode--;
		end
		start <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d requests (%0d traversals) and checked %0d results.",
			sb.requests, sb.traversals, sb.checked);
		$display("Rejections seen: %0d full, %0d empty, %0d out of range.",
			sb.full_hits, sb.empty_hits, sb.range_hits);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
